FILE: hdl/plbs_pkg.sv
// ----------------------------------------------------------------------------
// plbs_pkg
// Shared types, codes and the fixed pattern table of the priority LED blink
// sequencer.
// ----------------------------------------------------------------------------
package plbs_pkg;

  localparam int LED_COUNT_DEF   = 4;
  localparam int PRIO_LEVELS_DEF = 11;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic [1:0] MODE_KEEP_ON  = 2'd0;
  localparam logic [1:0] MODE_KEEP_OFF = 2'd1;
  localparam logic [1:0] MODE_ON_OFF   = 2'd2;
  localparam logic [1:0] MODE_OFF_ON   = 2'd3;

  localparam logic [7:0]  COUNT_FOREVER = 8'hFF;
  localparam logic [16:0] PHASE_MAX     = 17'h1FFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  count;
    logic [15:0] on_time;
    logic [15:0] off_time;
  } pattern_t;

  function automatic pattern_t pat_lookup(input logic [2:0] led, input logic [3:0] lvl);
    pattern_t p;
    p = '{MODE_KEEP_OFF, 8'd0, 16'd0, 16'd0};
    if (led == 3'd0) begin
      case (lvl)
        4'd0:    p = '{MODE_ON_OFF, 8'd1, 16'd10000, 16'd0};
        4'd1:    p = '{MODE_ON_OFF, 8'd3, 16'd2500, 16'd2500};
        4'd2:    p = '{MODE_ON_OFF, 8'd5, 16'd3000, 16'd3000};
        4'd3:    p = '{MODE_ON_OFF, COUNT_FOREVER, 16'd5000, 16'd5000};
        4'd4:    p = '{MODE_ON_OFF, 8'd1, 16'd10000, 16'd0};
        4'd5:    p = '{MODE_ON_OFF, 8'd3, 16'd1000, 16'd1000};
        4'd6:    p = '{MODE_ON_OFF, 8'd3, 16'd3000, 16'd3000};
        4'd7:    p = '{MODE_ON_OFF, COUNT_FOREVER, 16'd3000, 16'd3000};
        4'd8:    p = '{MODE_KEEP_ON, 8'd0, 16'd0, 16'd0};
        4'd9:    p = '{MODE_KEEP_ON, 8'd0, 16'd0, 16'd0};
        4'd10:   p = '{MODE_ON_OFF, COUNT_FOREVER, 16'd1080, 16'd1080};
        default: p = '{MODE_KEEP_OFF, 8'd0, 16'd0, 16'd0};
      endcase
    end
    return p;
  endfunction

  // lamp level of a pattern at phase zero
  function automatic logic phase0_lamp(input pattern_t p);
    logic lit;
    lit = 1'b0;
    case (p.mode)
      MODE_KEEP_ON:  lit = 1'b1;
      MODE_KEEP_OFF: lit = 1'b0;
      default: begin
        if (p.on_time != 16'd0) begin
          lit = (p.mode == MODE_ON_OFF);
        end else if (p.off_time != 16'd0) begin
          lit = (p.mode != MODE_ON_OFF);
        end else begin
          lit = 1'b0;
        end
      end
    endcase
    return lit;
  endfunction

endpackage

FILE: hdl/priority_led_blink_sequencer.sv
// ----------------------------------------------------------------------------
// priority_led_blink_sequencer
// Per-LED priority request tracking with blink pattern playback.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one item per tick, start or stop request
//   (in_opcode, in_led_select, in_request_priority). Each accepted item
//   yields exactly one item on the out_ channel: lamp levels of all LEDs
//   after the item, plus active level and pending mask of the addressed LED.
//   An item is taken when valid is high and stall is low on its channel.
//   An accepted item passes the input register, then the result register.
//   Throughput: one item per cycle while out_stall is low, set by the
//   single combinational pass from the input register into the per-LED
//   state and result registers. When the receiver stalls, the result
//   register holds and one more item can wait in the input register;
//   in_stall rises only when both are full. Reset (rst_n low, synchronous)
//   clears all requests, makes every LED inactive and dark, and empties
//   both registers.
// ----------------------------------------------------------------------------
module priority_led_blink_sequencer #(
  parameter int LED_COUNT       = plbs_pkg::LED_COUNT_DEF,
  parameter int PRIORITY_LEVELS = plbs_pkg::PRIO_LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [1:0]  in_led_select,
  input  logic [3:0]  in_request_priority,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_lamp_levels,
  output logic [3:0]  out_active_level,
  output logic [10:0] out_pending_mask
);
  import plbs_pkg::*;

  localparam int LW = $clog2(PRIORITY_LEVELS + 1);
  localparam int PL = PRIORITY_LEVELS;
  localparam logic [LW-1:0] NONE = LW'(PRIORITY_LEVELS);

  function automatic logic [LW-1:0] lowest(input logic [PL-1:0] bits);
    logic [LW-1:0] r;
    r = NONE;
    for (int j = PL - 1; j >= 0; j--) begin
      if (bits[j]) begin
        r = LW'(j);
      end
    end
    return r;
  endfunction

  logic          s1_v_r;
  logic [1:0]    s1_op_r;
  logic [1:0]    s1_led_r;
  logic [3:0]    s1_prio_r;
  logic          adv;
  logic          prio_ok;

  logic [PL-1:0] req_r   [LED_COUNT];
  logic [LW-1:0] act_r   [LED_COUNT];
  logic [7:0]    cnt_r   [LED_COUNT];
  logic [16:0]   ph_r    [LED_COUNT];
  logic [LED_COUNT-1:0] lamp_r;

  logic [PL-1:0] req_nxt [LED_COUNT];
  logic [LW-1:0] act_nxt [LED_COUNT];
  logic [7:0]    cnt_nxt [LED_COUNT];
  logic [16:0]   ph_nxt  [LED_COUNT];
  logic [LED_COUNT-1:0] lamp_nxt;

  logic          out_v_r;
  logic [3:0]    lamp_out_r;
  logic [3:0]    act_out_r;
  logic [10:0]   mask_out_r;
  logic [3:0]    act_out_nxt;
  logic [10:0]   mask_out_nxt;

  assign in_stall = s1_v_r && out_v_r && out_stall;
  assign adv      = s1_v_r && !(out_v_r && out_stall);
  assign prio_ok  = {1'b0, s1_prio_r} < 5'(PRIORITY_LEVELS);

  for (genvar i = 0; i < LED_COUNT; i++) begin : g_led
    always_comb begin
      logic [PL-1:0] rq;
      logic [LW-1:0] ac;
      logic [7:0]    ct;
      logic [16:0]   ph;
      logic          lp;
      logic          hit;
      logic [PL-1:0] pbit;
      pattern_t      pa;
      pattern_t      pn;
      logic [LW-1:0] nx;
      logic [16:0]   on17;
      logic [16:0]   tot;
      logic [7:0]    cd;
      rq   = req_r[i];
      ac   = act_r[i];
      ct   = cnt_r[i];
      ph   = ph_r[i];
      lp   = lamp_r[i];
      hit  = ({1'b0, s1_led_r} == 3'(i)) && prio_ok;
      pbit = PL'(1) << s1_prio_r;
      pa   = pat_lookup(3'(i), 4'(ac));
      pn   = pa;
      nx   = NONE;
      on17 = '0;
      tot  = '0;
      cd   = '0;

      case (s1_op_r)
        OP_TICK: begin
          if (ac < NONE && (pa.mode == MODE_ON_OFF || pa.mode == MODE_OFF_ON) &&
              ph != PHASE_MAX) begin
            ph = ph + 17'd1;
          end
        end
        OP_START: begin
          if (hit) begin
            rq = rq | pbit;
            if ({1'b0, s1_prio_r} <= 5'(ac)) begin
              nx = lowest(rq);
              ac = nx;
              pn = pat_lookup(3'(i), 4'(nx));
              ct = pn.count;
              ph = '0;
            end
          end
        end
        OP_STOP: begin
          if (hit && (rq & pbit) != '0) begin
            rq = rq & ~pbit;
            if ({1'b0, s1_prio_r} <= 5'(ac)) begin
              lp = 1'b0;
              nx = lowest(rq);
              ac = nx;
              if (nx < NONE) begin
                pn = pat_lookup(3'(i), 4'(nx));
                ct = pn.count;
                ph = '0;
              end
            end
          end
        end
        default: ;
      endcase

      // evaluate the active pattern
      if (ac < NONE) begin
        pa = pat_lookup(3'(i), 4'(ac));
        case (pa.mode)
          MODE_KEEP_ON:  lp = 1'b1;
          MODE_KEEP_OFF: lp = 1'b0;
          default: begin
            on17 = {1'b0, pa.on_time};
            tot  = on17 + {1'b0, pa.off_time};
            if (ph < on17) begin
              lp = (pa.mode == MODE_ON_OFF);
            end else if (ph < tot) begin
              lp = (pa.mode != MODE_ON_OFF);
            end else begin
              ph = '0;
              cd = (ct != 8'd0 && ct != COUNT_FOREVER) ? ct - 8'd1 : ct;
              ct = cd;
              if (cd != 8'd0) begin
                lp = phase0_lamp(pa);
              end else begin
                rq = rq & ~(PL'(1) << ac);
                nx = lowest(rq);
                ac = nx;
                lp = 1'b0;
                if (nx < NONE) begin
                  pn = pat_lookup(3'(i), 4'(nx));
                  ct = pn.count;
                  lp = phase0_lamp(pn);
                end
              end
            end
          end
        endcase
      end

      req_nxt[i]  = rq;
      act_nxt[i]  = ac;
      cnt_nxt[i]  = ct;
      ph_nxt[i]   = ph;
      lamp_nxt[i] = lp;
    end
  end

  always_comb begin
    act_out_nxt  = 4'(PRIORITY_LEVELS);
    mask_out_nxt = '0;
    for (int k = 0; k < LED_COUNT; k++) begin
      if ({1'b0, s1_led_r} == 3'(k)) begin
        act_out_nxt  = 4'(act_nxt[k]);
        mask_out_nxt = 11'(req_nxt[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      lamp_r  <= '0;
      for (int k = 0; k < LED_COUNT; k++) begin
        req_r[k] <= '0;
        act_r[k] <= NONE;
        cnt_r[k] <= '0;
        ph_r[k]  <= '0;
      end
    end else begin
      if (!in_stall) begin
        s1_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
        lamp_r  <= lamp_nxt;
        for (int k = 0; k < LED_COUNT; k++) begin
          req_r[k] <= req_nxt[k];
          act_r[k] <= act_nxt[k];
          cnt_r[k] <= cnt_nxt[k];
          ph_r[k]  <= ph_nxt[k];
        end
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r   <= in_opcode;
      s1_led_r  <= in_led_select;
      s1_prio_r <= in_request_priority;
    end
    if (adv) begin
      lamp_out_r <= 4'(lamp_nxt);
      act_out_r  <= act_out_nxt;
      mask_out_r <= mask_out_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_lamp_levels  = lamp_out_r;
  assign out_active_level = act_out_r;
  assign out_pending_mask = mask_out_r;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority LED blink sequencer. Directed starts,
// stops, ticks and ignored requests come first, then random request and tick
// sequences with one long tick run so that a blink phase runs out.
// A scoreboard predicts every result item and checks all three fields.
// ----------------------------------------------------------------------------
module tb_top;
  import plbs_pkg::*;

  localparam int         LEDS         = LED_COUNT_DEF;
  localparam int         LEVELS       = PRIO_LEVELS_DEF;
  localparam logic [1:0] OP_NONE      = 2'd3;
  localparam int         RANDOM_ITEMS = 1450;
  localparam int         LEVEL_TICKS  = 1100;
  localparam int         QUIET_LIMIT  = 4000;

  typedef struct {
    logic [3:0]  lamps;
    logic [3:0]  level;
    logic [10:0] mask;
  } lamp_result_t;

  class lamp_scoreboard;
    logic [10:0]  req_bits[LEDS];
    logic [3:0]   act_lvl[LEDS];
    logic [7:0]   reps[LEDS];
    logic [16:0]  phase[LEDS];
    logic [3:0]   lamps;
    lamp_result_t due_results[$];
    int           errors;

    function new();
      for (int i = 0; i < LEDS; i++) begin
        req_bits[i] = '0;
        act_lvl[i]  = 4'(LEVELS);
        reps[i]     = '0;
        phase[i]    = '0;
      end
      lamps  = '0;
      errors = 0;
    endfunction

    // only LED 0 carries blink patterns, every other entry is dark
    function pattern_t led_pattern(int led, int lvl);
      pattern_t p;
      p = {MODE_KEEP_OFF, 8'd0, 16'd0, 16'd0};
      if (led == 0) begin
        case (lvl)
          0, 4: p = {MODE_ON_OFF, 8'd1, 16'd10000, 16'd0};
          1:    p = {MODE_ON_OFF, 8'd3, 16'd2500, 16'd2500};
          2:    p = {MODE_ON_OFF, 8'd5, 16'd3000, 16'd3000};
          3:    p = {MODE_ON_OFF, COUNT_FOREVER, 16'd5000, 16'd5000};
          5:    p = {MODE_ON_OFF, 8'd3, 16'd1000, 16'd1000};
          6:    p = {MODE_ON_OFF, 8'd3, 16'd3000, 16'd3000};
          7:    p = {MODE_ON_OFF, COUNT_FOREVER, 16'd3000, 16'd3000};
          8, 9: p = {MODE_KEEP_ON, 8'd0, 16'd0, 16'd0};
          10:   p = {MODE_ON_OFF, COUNT_FOREVER, 16'd1080, 16'd1080};
          default: ;
        endcase
      end
      return p;
    endfunction

    function void pick_next(int led);
      pattern_t p;
      for (int j = 0; j < LEVELS; j++) begin
        if (req_bits[led][j]) begin
          if (j < act_lvl[led]) begin
            p            = led_pattern(led, j);
            act_lvl[led] = 4'(j);
            reps[led]    = p.count;
            phase[led]   = '0;
          end
          return;
        end
      end
    endfunction

    function void settle(int led);
      pattern_t p;
      int       a;
      int       on_t;
      int       total;
      logic     first;
      for (int g = 0; g < 2 * LEVELS + 2; g++) begin
        a = int'(act_lvl[led]);
        if (a >= LEVELS) return;
        p = led_pattern(led, a);
        if (p.mode == MODE_KEEP_ON) begin
          lamps[led] = 1'b1;
          return;
        end
        if (p.mode == MODE_KEEP_OFF) begin
          lamps[led] = 1'b0;
          return;
        end
        first = (p.mode == MODE_ON_OFF);
        on_t  = int'(p.on_time);
        total = on_t + int'(p.off_time);
        if (int'(phase[led]) < on_t) begin
          lamps[led] = first;
          return;
        end
        if (int'(phase[led]) < total) begin
          lamps[led] = !first;
          return;
        end
        phase[led] = '0;
        if (reps[led] != 8'd0 && reps[led] != COUNT_FOREVER) reps[led]--;
        if (reps[led] != 8'd0) begin
          if (total == 0) begin
            lamps[led] = 1'b0;
            return;
          end
        end else begin
          req_bits[led][a] = 1'b0;
          act_lvl[led]     = 4'(LEVELS);
          lamps[led]       = 1'b0;
          pick_next(led);
        end
      end
    endfunction

    function void note_item(logic [1:0] op, logic [1:0] led, logic [3:0] prio);
      lamp_result_t r;
      pattern_t     pm;
      if (op == OP_TICK) begin
        for (int i = 0; i < LEDS; i++) begin
          if (act_lvl[i] < LEVELS) begin
            pm = led_pattern(i, int'(act_lvl[i]));
            if ((pm.mode == MODE_ON_OFF || pm.mode == MODE_OFF_ON) &&
                phase[i] < PHASE_MAX) phase[i]++;
          end
        end
      end else if (op == OP_START && prio < LEVELS) begin
        req_bits[led][prio] = 1'b1;
        if (prio <= act_lvl[led]) begin
          act_lvl[led] = 4'(LEVELS);
          pick_next(led);
        end
      end else if (op == OP_STOP && prio < LEVELS && req_bits[led][prio]) begin
        req_bits[led][prio] = 1'b0;
        if (prio <= act_lvl[led]) begin
          act_lvl[led] = 4'(LEVELS);
          lamps[led]   = 1'b0;
          pick_next(led);
        end
      end
      for (int i = 0; i < LEDS; i++) settle(i);
      r.lamps = lamps;
      r.level = act_lvl[led];
      r.mask  = req_bits[led];
      due_results.push_back(r);
    endfunction

    function void check_result(logic [3:0] lamps_got, logic [3:0] level_got,
                               logic [10:0] mask_got);
      lamp_result_t r;
      if (due_results.size() == 0) begin
        $error("result item with none expected: lamp_levels %h", lamps_got);
        errors++;
        return;
      end
      r = due_results.pop_front();
      if (lamps_got !== r.lamps) begin
        $error("lamp_levels: expected %h, got %h", r.lamps, lamps_got);
        errors++;
      end
      if (level_got !== r.level) begin
        $error("active_level: expected %0d, got %0d", r.level, level_got);
        errors++;
      end
      if (mask_got !== r.mask) begin
        $error("pending_mask: expected %h, got %h", r.mask, mask_got);
        errors++;
      end
    endfunction

    function int backlog();
      return due_results.size();
    endfunction
  endclass

  logic        clk                 = 1'b0;
  logic        rst_n               = 1'b0;
  logic        in_valid            = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode           = OP_TICK;
  logic [1:0]  in_led_select       = 2'd0;
  logic [3:0]  in_request_priority = 4'd0;
  logic        out_valid;
  logic        out_stall           = 1'b0;
  logic [3:0]  out_lamp_levels;
  logic [3:0]  out_active_level;
  logic [10:0] out_pending_mask;

  logic           idling = 1'b1;
  int             quiet  = 0;
  lamp_scoreboard sb     = new();

  priority_led_blink_sequencer i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_led_select       (in_led_select),
    .in_request_priority (in_request_priority),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_lamp_levels     (out_lamp_levels),
    .out_active_level    (out_active_level),
    .out_pending_mask    (out_pending_mask)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= idling && ($urandom_range(99) < 37);
  end

  // handshakes are sampled mid-cycle, where everything is settled
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_item(in_opcode, in_led_select, in_request_priority);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_lamp_levels, out_active_level, out_pending_mask);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [1:0] led,
                           input logic [3:0] prio);
    logic stalled;
    while (idling && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_opcode           <= op;
    in_led_select       <= led;
    in_request_priority <= prio;
    forever begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
    end
  endtask

  task automatic send_ticks(input int count);
    for (int k = 0; k < count; k++) begin
      send_item(OP_TICK, 2'($urandom_range(3)), 4'($urandom_range(15)));
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.backlog() != 0) @(posedge clk);
  endtask

  // clear LED 0, then hold one level long enough for its lamp to change
  task automatic run_level_out(input logic [3:0] lvl, input int ticks);
    for (int j = 0; j < LEVELS; j++) begin
      if (sb.req_bits[0][j]) send_item(OP_STOP, 2'd0, 4'(j));
    end
    send_item(OP_START, 2'd0, lvl);
    send_ticks(ticks);
  endtask

  initial begin
    int          n;
    int          pick;
    logic [1:0]  led;
    logic [3:0]  prio;
    logic [10:0] mask;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_item(OP_TICK, 2'd0, 4'd0);
    send_item(OP_START, 2'd0, 4'd10);
    send_item(OP_TICK, 2'd0, 4'd15);
    send_item(OP_START, 2'd0, 4'd8);
    send_item(OP_START, 2'd0, 4'd9);
    send_item(OP_START, 2'd0, 4'd8);
    send_item(OP_STOP, 2'd0, 4'd9);
    send_item(OP_STOP, 2'd0, 4'd9);
    send_item(OP_STOP, 2'd0, 4'd8);
    send_item(OP_START, 2'd1, 4'd0);
    send_item(OP_START, 2'd2, 4'd5);
    send_item(OP_START, 2'd3, 4'd10);
    send_item(OP_STOP, 2'd3, 4'd10);
    send_item(OP_START, 2'd0, 4'd15);
    send_item(OP_STOP, 2'd0, 4'd11);
    send_item(OP_NONE, 2'd3, 4'd15);
    send_item(OP_START, 2'd0, 4'd0);
    send_item(OP_TICK, 2'd1, 4'd0);
    send_item(OP_STOP, 2'd0, 4'd0);
    send_item(OP_START, 2'd0, 4'd3);
    send_item(OP_TICK, 2'd3, 4'd7);
    send_item(OP_STOP, 2'd0, 4'd10);

    // random
    n = 0;
    while (n < RANDOM_ITEMS) begin
      idling = !(n >= 200 && n < 1400);
      if (n >= 100 && n < 120) begin
        drain_results();
        n = 120;
      end
      if (n >= 200 && n < 220) begin
        run_level_out(4'd10, LEVEL_TICKS);
        n += LEVEL_TICKS + 1;
      end
      pick = $urandom_range(99);
      led  = $urandom_range(1) ? 2'd0 : 2'($urandom_range(3));
      if (pick < 10) begin
        send_item(2'($urandom_range(3)), 2'($urandom_range(3)), 4'($urandom_range(15)));
        n++;
      end else if (pick < 35) begin
        send_item(OP_START, led, 4'($urandom_range(LEVELS - 1)));
        n++;
      end else if (pick < 55) begin
        mask = sb.req_bits[led];
        prio = 4'($urandom_range(LEVELS - 1));
        if (mask != '0 && $urandom_range(3) != 0) begin
          while (!mask[prio]) prio = 4'($urandom_range(LEVELS - 1));
        end
        send_item(OP_STOP, led, prio);
        n++;
      end else if (pick < 98) begin
        pick = $urandom_range(1, 20);
        send_ticks(pick);
        n += pick;
      end else begin
        pick = $urandom_range(20, 60);
        send_ticks(pick);
        n += pick;
      end
    end

    in_valid <= 1'b0;
    idling = 1'b1;
    while (sb.backlog() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.backlog() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
